// File: rtl/core/h2st_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/2 stream table package
// Shared types, codes and the stream state transition function.
// ----------------------------------------------------------------------------
package h2st_pkg;

    // Table size default
    localparam int MAX_STREAMS_DEF = 128;

    // Field widths
    localparam int ID_W     = 31;
    localparam int WIN_W    = 31;
    localparam int FTYPE_W  = 8;
    localparam int FLAGS_W  = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 7;
    localparam int STATE_W  = 3;
    localparam int ENTRY_W  = ID_W + STATE_W + WIN_W;

    localparam logic [WIN_W-1:0] INIT_WIN_RST = 31'd65535;

    // Frame type codes
    localparam logic [FTYPE_W-1:0] FT_HEADERS  = 8'd1;
    localparam logic [FTYPE_W-1:0] FT_PRIORITY = 8'd2;
    localparam logic [FTYPE_W-1:0] FT_RST      = 8'd3;
    localparam logic [FTYPE_W-1:0] FT_WINUPD   = 8'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_STATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Stream states
    typedef enum logic [STATE_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_OPEN   = 3'd1,
        ST_HCL    = 3'd2,
        ST_HCR    = 3'd3,
        ST_CLOSED = 3'd4
    } stream_st_t;

    // Engine sequencer states
    typedef enum logic [1:0] {
        E_IDLE,
        E_SCAN,
        E_APPLY,
        E_DONE
    } eng_state_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        stream_st_t       st;
        logic [WIN_W-1:0] window;
    } entry_t;

    // One frame event
    typedef struct packed {
        logic [ID_W-1:0]    sid;
        logic [FTYPE_W-1:0] ftype;
        logic [FLAGS_W-1:0] flags;
        logic               snd;
    } frame_t;

    // One result
    typedef struct packed {
        logic [ID_W-1:0]     highest_id;
        logic [WIN_W-1:0]    window;
        logic                new_entry;
        logic [STATE_W-1:0]  st;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic       ok;
        stream_st_t nxt;
    } trans_t;

    // Stream state transition for one frame
    function automatic trans_t h2st_apply(stream_st_t cur, logic [FTYPE_W-1:0] ft,
                                          logic end_f, logic snd);
        trans_t r;
        logic   rst_f;
        logic   benign;
        logic   peer;
        rst_f  = (ft == FT_RST);
        benign = (ft == FT_PRIORITY) || (ft == FT_WINUPD);
        peer   = 1'b0;
        r.nxt  = cur;
        r.ok   = 1'b0;
        case (cur)
            ST_IDLE: begin
                if (ft == FT_HEADERS) begin
                    r.nxt = end_f ? (snd ? ST_HCL : ST_HCR) : ST_OPEN;
                    r.ok  = 1'b1;
                end else begin
                    r.ok = (ft == FT_PRIORITY);
                end
            end
            ST_OPEN: begin
                r.ok = 1'b1;
                if (rst_f) begin
                    r.nxt = ST_CLOSED;
                end else if (end_f) begin
                    r.nxt = snd ? ST_HCL : ST_HCR;
                end
            end
            ST_HCL, ST_HCR: begin
                // frames from the side that has not yet closed its half
                peer = (cur == ST_HCL) ? !snd : snd;
                if (rst_f) begin
                    r.nxt = ST_CLOSED;
                    r.ok  = 1'b1;
                end else if (peer) begin
                    r.ok = 1'b1;
                    if (end_f) begin
                        r.nxt = ST_CLOSED;
                    end
                end else begin
                    r.ok = benign;
                end
            end
            ST_CLOSED: begin
                r.ok = benign;
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/h2st_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module h2st_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/h2st_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/2 stream table engine
// Scans the table memory for the frame's stream id, creates a missing entry
// while there is room, applies the state transition and writes it back.
// ----------------------------------------------------------------------------
module h2st_engine #(
    parameter int MAX_STREAMS = h2st_pkg::MAX_STREAMS_DEF,
    parameter int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
    parameter int CNT_W       = $clog2(MAX_STREAMS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // frame input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  h2st_pkg::frame_t              s_frame,
    input  logic [h2st_pkg::WIN_W-1:0]    init_window,
    // result handoff
    output logic                          res_valid,
    input  logic                          res_ready,
    output h2st_pkg::result_t             res,
    // table memory
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [h2st_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  logic [h2st_pkg::ENTRY_W-1:0]  mem_rdata
);

    import h2st_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STREAMS);

    eng_state_t           state_reg, state_next;
    logic [ID_W-1:0]      sid_reg, sid_next;
    logic [FTYPE_W-1:0]   ftype_reg, ftype_next;
    logic                 end_reg, end_next;
    logic                 snd_reg, snd_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 found_reg, found_next;
    entry_t               entry_reg, entry_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      max_id_reg, max_id_next;
    result_t              res_reg, res_next;

    entry_t               rd_entry;
    entry_t               cur_entry;
    entry_t               new_entry;
    trans_t               tr;
    logic [IDX_W-1:0]     apply_slot;
    logic [31:0]          slot_ext;
    logic                 issue_en;

    assign rd_entry = entry_t'(mem_rdata);

    // Sequencer state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= E_IDLE;
            pend_reg   <= 1'b0;
            count_reg  <= '0;
            max_id_reg <= '0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            max_id_reg <= max_id_next;
        end
        sid_reg     <= sid_next;
        ftype_reg   <= ftype_next;
        end_reg     <= end_next;
        snd_reg     <= snd_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        entry_reg   <= entry_next;
        res_reg     <= res_next;
    end

    // Entry under update: the one found, or a fresh idle entry
    always_comb begin
        cur_entry.id     = sid_reg;
        cur_entry.st     = ST_IDLE;
        cur_entry.window = init_window;
        if (found_reg) begin
            cur_entry = entry_reg;
        end
        apply_slot = found_reg ? slot_reg : count_reg[IDX_W-1:0];
        tr         = h2st_apply(cur_entry.st, ftype_reg, end_reg, snd_reg);
        new_entry        = cur_entry;
        new_entry.st     = tr.nxt;
        slot_ext         = 32'(apply_slot);
    end

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        sid_next     = sid_reg;
        ftype_next   = ftype_reg;
        end_next     = end_reg;
        snd_next     = snd_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        entry_next   = entry_reg;
        count_next   = count_reg;
        max_id_next  = max_id_reg;
        res_next     = res_reg;
        s_ready      = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = apply_slot;
        mem_wdata    = new_entry;
        mem_raddr    = issue_reg[IDX_W-1:0];
        issue_en     = 1'b0;

        case (state_reg)
            E_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sid_next   = s_frame.sid;
                    ftype_next = s_frame.ftype;
                    end_next   = s_frame.flags[0];
                    snd_next   = s_frame.snd;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = (count_reg == '0) ? E_APPLY : E_SCAN;
                end
            end
            E_SCAN: begin
                // one read issued per cycle, compared on the next
                issue_en     = (issue_reg < count_reg);
                pend_next    = issue_en;
                cmp_idx_next = issue_reg[IDX_W-1:0];
                if (issue_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    if (rd_entry.id == sid_reg) begin
                        found_next = 1'b1;
                        slot_next  = cmp_idx_reg;
                        entry_next = rd_entry;
                        pend_next  = 1'b0;
                        state_next = E_APPLY;
                    end else if (CNT_W'(cmp_idx_reg) + CNT_W'(1) == count_reg) begin
                        found_next = 1'b0;
                        pend_next  = 1'b0;
                        state_next = E_APPLY;
                    end
                end
            end
            E_APPLY: begin
                if (!found_reg && count_reg == MAX_CNT) begin
                    // table full: nothing stored
                    res_next.status     = STATUS_FULL;
                    res_next.slot       = '0;
                    res_next.st         = ST_IDLE;
                    res_next.new_entry  = 1'b0;
                    res_next.window     = '0;
                    res_next.highest_id = max_id_reg;
                end else begin
                    mem_we = 1'b1;
                    if (!found_reg) begin
                        count_next = count_reg + CNT_W'(1);
                        if (sid_reg > max_id_reg) begin
                            max_id_next = sid_reg;
                        end
                    end
                    res_next.status     = tr.ok ? STATUS_OK : STATUS_BAD_STATE;
                    res_next.slot       = slot_ext[SLOT_W-1:0];
                    res_next.st         = tr.nxt;
                    res_next.new_entry  = !found_reg;
                    res_next.window     = cur_entry.window;
                    res_next.highest_id = (!found_reg && sid_reg > max_id_reg) ?
                                          sid_reg : max_id_reg;
                end
                state_next = E_DONE;
            end
            E_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = E_IDLE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("entry count exceeds table size");

    a_write_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == E_APPLY) && (found_reg || count_reg < MAX_CNT))
        else $error("table write outside update or into a full table");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second frame taken while one is in flight");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != E_APPLY) |=> ($stable(count_reg) && $stable(max_id_reg)))
        else $error("count or highest id changed outside update");

endmodule

// File: rtl/core/http2_stream_table_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/2 stream table and stream state machine
// Tracks per-stream state in a table memory and returns one result per frame.
// ----------------------------------------------------------------------------
// One frame event is taken at a time. The stream table sits in a single
// memory with one read port, and the id lookup scans the entries created so
// far one per cycle until a match or a miss is known (at most the current
// fill), so a new frame is not taken before the last result is handed off.
// An empty table skips the scan. The entry count acts as the table's valid
// mark, so no clearing pass follows reset. The result sits in an output
// register, so the next frame is accepted while a result still waits for
// m_tready.
// The initial window (cfg_wr_en / cfg_wr_data) must only change while idle.
module http2_stream_table_state_machine #(
    parameter int MAX_STREAMS = h2st_pkg::MAX_STREAMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration: initial window for new streams
    input  logic                       cfg_wr_en,
    input  logic [h2st_pkg::WIN_W-1:0] cfg_wr_data,
    // frame events
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // sid[30:0], frame_flags[38:31],
                                                  // sender[39]
    input  logic [7:0]                 s_tuser,   // ftype[7:0]
    // results
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata    // status[1:0], slot[8:2],
                                                  // stream_state[11:9], new_entry[12],
                                                  // stream_window[43:13],
                                                  // highest_id[74:44], zero
);

    import h2st_pkg::*;

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);

    logic [WIN_W-1:0]   init_win_reg;
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    frame_t             frame;
    result_t            res;
    logic               res_valid;
    logic               res_ready;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    // Unpack input transfer
    assign frame.sid   = s_tdata[30:0];
    assign frame.flags = s_tdata[38:31];
    assign frame.snd   = s_tdata[39];
    assign frame.ftype = s_tuser;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_win_reg <= INIT_WIN_RST;
        end else if (cfg_wr_en) begin
            init_win_reg <= cfg_wr_data;
        end
    end

    // Output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_res_reg.highest_id, m_res_reg.window, m_res_reg.new_entry,
                       m_res_reg.st, m_res_reg.slot, m_res_reg.status};

    h2st_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STREAMS),
        .AW    (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    h2st_engine #(
        .MAX_STREAMS (MAX_STREAMS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_frame     (frame),
        .init_window (init_win_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule

// File: dv/stream_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/2 stream table checker
// Watches the configuration port and both stream channels. It keeps its own
// stream table and window setting, predicts one result for every accepted
// frame, and compares every result transfer field by field with the oldest
// prediction that is still outstanding.
// ----------------------------------------------------------------------------
module stream_table_checker #(
    parameter int TABLE_DEPTH = h2st_pkg::MAX_STREAMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [h2st_pkg::WIN_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [39:0]                s_tdata,   // sid[30:0], frame_flags[38:31],
                                                  // sender[39]
    input  logic [7:0]                 s_tuser,   // ftype[7:0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [79:0]                m_tdata,   // status[1:0], slot[8:2],
                                                  // stream_state[11:9], new_entry[12],
                                                  // stream_window[43:13],
                                                  // highest_id[74:44], zero
    output int                         results_due,
    output int                         mismatch_count
);
    import h2st_pkg::*;

    // Shadow stream table
    logic [ID_W-1:0]  tbl_id  [TABLE_DEPTH];
    stream_st_t       tbl_st  [TABLE_DEPTH];
    logic [WIN_W-1:0] tbl_win [TABLE_DEPTH];
    int               tbl_fill;
    logic [ID_W-1:0]  top_id;
    logic [WIN_W-1:0] new_stream_window;

    // Predicted results, oldest first
    result_t          pending_results[$];
    result_t          want;
    result_t          seen;

    // Stream state after one frame; a refused frame keeps the state
    function automatic void stream_next(input stream_st_t cur, input logic [FTYPE_W-1:0] ft,
                                        input logic fin, input logic tx,
                                        output logic ok, output stream_st_t nxt);
        logic       harmless;
        logic       far_side_open;
        stream_st_t our_half;
        harmless      = (ft == FT_PRIORITY) || (ft == FT_WINUPD);
        our_half      = tx ? ST_HCL : ST_HCR;
        far_side_open = (cur == ST_HCL) ? !tx : tx;
        nxt           = cur;
        ok            = 1'b0;
        case (cur)
            ST_IDLE: begin
                if (ft == FT_HEADERS) begin
                    ok  = 1'b1;
                    nxt = fin ? our_half : ST_OPEN;
                end else begin
                    ok = (ft == FT_PRIORITY);
                end
            end
            ST_OPEN: begin
                ok = 1'b1;
                if (ft == FT_RST)
                    nxt = ST_CLOSED;
                else if (fin)
                    nxt = our_half;
            end
            ST_HCL, ST_HCR: begin
                if (ft == FT_RST) begin
                    ok  = 1'b1;
                    nxt = ST_CLOSED;
                end else if (far_side_open) begin
                    ok = 1'b1;
                    if (fin)
                        nxt = ST_CLOSED;
                end else begin
                    ok = harmless;
                end
            end
            ST_CLOSED: ok = harmless;
            default:   ok = 1'b0;
        endcase
    endfunction

    // Table lookup, stream creation and transition for one frame
    function automatic result_t advance_stream(logic [ID_W-1:0] sid, logic [FTYPE_W-1:0] ft,
                                               logic fin, logic tx);
        result_t    r;
        int         idx;
        logic       ok;
        stream_st_t nxt;
        r   = '0;
        idx = -1;
        for (int i = 0; i < tbl_fill; i++) begin
            if (idx < 0 && tbl_id[i] == sid)
                idx = i;
        end
        if (idx < 0) begin
            if (tbl_fill >= TABLE_DEPTH) begin
                r.status     = STATUS_FULL;
                r.highest_id = top_id;
                return r;
            end
            idx          = tbl_fill;
            tbl_fill     = tbl_fill + 1;
            tbl_id[idx]  = sid;
            tbl_st[idx]  = ST_IDLE;
            tbl_win[idx] = new_stream_window;
            if (sid > top_id)
                top_id = sid;
            r.new_entry = 1'b1;
        end
        stream_next(tbl_st[idx], ft, fin, tx, ok, nxt);
        tbl_st[idx]  = nxt;
        r.status     = ok ? STATUS_OK : STATUS_BAD_STATE;
        r.slot       = idx[SLOT_W-1:0];
        r.st         = nxt;
        r.window     = tbl_win[idx];
        r.highest_id = top_id;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] seen_v);
        if (want_v !== seen_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, seen_v);
            mismatch_count++;
        end
    endtask

    // Predict on each frame transfer, compare on each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            tbl_fill          = 0;
            top_id            = '0;
            new_stream_window = INIT_WIN_RST;
            pending_results.delete();
        end else begin
            if (cfg_wr_en)
                new_stream_window = cfg_wr_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(advance_stream(s_tdata[30:0], s_tuser,
                                                         s_tdata[31], s_tdata[39]));
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no frame outstanding: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    seen = m_tdata[74:0];
                    check_field("status", want.status, seen.status);
                    check_field("slot", want.slot, seen.slot);
                    check_field("stream_state", want.st, seen.st);
                    check_field("new_entry", want.new_entry, seen.new_entry);
                    check_field("stream_window", want.window, seen.window);
                    check_field("highest_id", want.highest_id, seen.highest_id);
                    check_field("tdata padding", '0, m_tdata[79:75]);
                end
            end
        end
        results_due = pending_results.size();
    end

endmodule

// File: dv/tb_http2_stream_table_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/2 stream table testbench
// Drives frame events into the stream table with random gaps and result
// stalls: a directed walk through every stream state and frame kind, then
// random stream lifecycles mixed with noise frames until the table fills,
// under several initial window settings. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_http2_stream_table_state_machine;
    import h2st_pkg::*;

    localparam int                 CYCLE_LIMIT     = 2_000_000;
    localparam logic [FTYPE_W-1:0] FT_DATA         = 8'd0;
    localparam logic [FLAGS_W-1:0] FLAG_FIN        = 8'h01;
    localparam logic [ID_W-1:0]    ID_MAX          = 31'h7FFF_FFFF;
    localparam logic [WIN_W-1:0]   WIN_MAX         = 31'h7FFF_FFFF;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [WIN_W-1:0]   cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // sid[30:0], frame_flags[38:31], sender[39]
    logic [7:0]         s_tuser;   // ftype[7:0]
    logic               m_tvalid;
    logic               m_tready;
    logic [79:0]        m_tdata;   // status[1:0], slot[8:2], stream_state[11:9],
                                   // new_entry[12], stream_window[43:13],
                                   // highest_id[74:44], zero

    int                 results_due;
    int                 mismatch_count;
    int unsigned        cycle_count;
    int unsigned        stall_left;
    logic               quiet;     // no gaps and no new stalls while set
    logic [ID_W-1:0]    opened_ids[$];

    http2_stream_table_state_machine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    stream_table_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // One frame transfer, after an optional gap; called at a rising edge
    task automatic send_frame(logic [ID_W-1:0] sid, logic [FTYPE_W-1:0] ft,
                              logic [FLAGS_W-1:0] flags, logic snd);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {snd, flags, sid};
        s_tuser  <= ft;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        @(posedge aclk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Up to four interleaved stream lifecycles plus a share of noise frames
    task automatic random_traffic(int unsigned n_items);
        logic [ID_W-1:0]    live_id [4];
        int unsigned        burst_left [4];
        int unsigned        k;
        logic [ID_W-1:0]    sid;
        logic [FTYPE_W-1:0] ft;
        logic [FLAGS_W-1:0] flags;
        foreach (burst_left[j])
            burst_left[j] = 0;
        repeat (n_items) begin
            flags = 8'($urandom);
            if ($urandom_range(0, 99) < 8) begin
                // noise: any code, any flags, on a fresh, reused or tiny id
                case ($urandom_range(0, 2))
                    0: sid = 31'($urandom);
                    1: sid = (opened_ids.size() != 0) ?
                             opened_ids[$urandom_range(0, opened_ids.size() - 1)] : '0;
                    default: sid = 31'($urandom_range(0, 15));
                endcase
                send_frame(sid, 8'($urandom), flags, 1'($urandom));
            end else begin
                k = $urandom_range(0, 3);
                if (burst_left[k] == 0) begin
                    // start a new stream, usually with HEADERS
                    live_id[k] = ($urandom_range(0, 3) == 0) ?
                                 31'($urandom_range(1, 4095)) : 31'($urandom);
                    opened_ids.push_back(live_id[k]);
                    burst_left[k] = $urandom_range(4, 16);
                    ft = ($urandom_range(0, 7) == 0) ? FT_PRIORITY : FT_HEADERS;
                end else begin
                    burst_left[k]--;
                    case ($urandom_range(0, 11))
                        0, 1:    ft = FT_HEADERS;
                        2:       ft = FT_PRIORITY;
                        3, 4:    ft = FT_WINUPD;
                        5:       ft = FT_RST;
                        6:       ft = 8'($urandom_range(9, 255));  // plain frame
                        default: ft = FT_DATA;
                    endcase
                end
                flags[0] = ($urandom_range(0, 3) == 0);
                send_frame(live_id[k], ft, flags, 1'($urandom));
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        quiet       = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stream id zero: idle, open, half-closed local, closed
        send_frame('0, FT_PRIORITY, '0, 1'b0);
        send_frame('0, FT_HEADERS, ~FLAG_FIN, 1'b1);
        send_frame('0, FT_DATA, 8'hFF, 1'b1);
        send_frame('0, FT_DATA, '0, 1'b1);
        send_frame('0, FT_WINUPD, '0, 1'b1);
        send_frame('0, FT_DATA, FLAG_FIN, 1'b0);
        send_frame('0, FT_HEADERS, '0, 1'b0);
        send_frame('0, FT_PRIORITY, '0, 1'b0);
        // largest id: unknown code refused in idle, then half-closed remote
        send_frame(ID_MAX, 8'hFF, '0, 1'b0);
        send_frame(ID_MAX, FT_HEADERS, FLAG_FIN, 1'b0);
        send_frame(ID_MAX, FT_DATA, '0, 1'b1);
        send_frame(ID_MAX, FT_DATA, '0, 1'b0);
        send_frame(ID_MAX, FT_RST, '0, 1'b0);
        send_frame(ID_MAX, FT_RST, '0, 1'b1);
        // window update refused in idle; reset from half-closed local
        send_frame(31'd5, FT_WINUPD, '0, 1'b1);
        send_frame(31'd5, FT_HEADERS, FLAG_FIN, 1'b1);
        send_frame(31'd5, FT_RST, '0, 1'b1);
        // reset from open, reset with the end flag set
        send_frame(31'd7, FT_HEADERS, '0, 1'b0);
        send_frame(31'd7, FT_RST, '0, 1'b0);
        send_frame(31'd9, FT_HEADERS, '0, 1'b1);
        send_frame(31'd9, FT_WINUPD, '0, 1'b0);
        send_frame(31'd9, FT_RST, 8'hFF, 1'b1);
        // half-closed remote: own-side priority, then our end of stream closes
        send_frame(31'd11, FT_HEADERS, 8'hFF, 1'b0);
        send_frame(31'd11, FT_PRIORITY, '0, 1'b0);
        send_frame(31'd11, FT_HEADERS, FLAG_FIN, 1'b1);
        drain();

        write_window('0);
        random_traffic(430);
        drain();

        write_window(WIN_MAX);
        quiet = 1'b1;
        random_traffic(150);
        quiet = 1'b0;
        random_traffic(280);
        drain();

        write_window(31'($urandom));
        random_traffic(430);
        drain();

        write_window(31'($urandom));
        random_traffic(430);
        drain();

        repeat (150) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
